// ----- rtl/core/max_pool_2d_stream_core_defines.svh -----
// Assertion macros used by the top level of the max pooling core.
`ifndef MAX_POOL_2D_STREAM_CORE_DEFINES_SVH
`define MAX_POOL_2D_STREAM_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked on every rising edge of clk_i outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked on every rising edge of clk_i outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- rtl/core/mp2_pkg.sv -----
// Shared constants and types of the max pooling core.
`default_nettype none
package mp2_pkg;

  // Default parameter values.
  localparam int DEF_MAX_MAP_WIDTH = 1024;
  localparam int DEF_MAX_POOL      = 8;
  localparam int DEF_SAMPLE_BITS   = 16;

  // Configuration register file.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 11;
  localparam int POOL_REG_BITS  = 4;
  localparam int MAP_REG_BITS   = 11;

  localparam logic [CFG_INDEX_BITS-1:0] REG_POOL_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_POOL_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAP_WIDTH   = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAP_HEIGHT  = 2'd3;

  // Reset values of the registers before clamping.
  localparam int POOL_RESET = 2;
  localparam int MAP_RESET  = 1024;

  // The map height is bounded independently of the line store depth.
  localparam int HEIGHT_LIMIT = 1024;
  localparam int ROW_BITS     = 10;
  localparam int MH_BITS      = 11;

  // Per-item control flags handed from the window counters to stage 1.
  typedef struct packed {
    logic use_line;  // window row is not the first, so the line entry is valid
    logic col_end;   // item closes the window's columns in this row
    logic row_end;   // item lies on the window's bottom row
    logic last;      // result of this item is the final one of the map
  } win_flags_t;

endpackage
`default_nettype wire

// ----- rtl/core/mp2_line_mem.sv -----
// Line store of partial window maxima: one write port, one registered read port.
`default_nettype none
module mp2_line_mem #(
  parameter int DEPTH = mp2_pkg::DEF_MAX_MAP_WIDTH,
  parameter int WIDTH = mp2_pkg::DEF_SAMPLE_BITS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read, so a stalled consumer keeps it.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/mp2_window_ctrl.sv -----
// Configuration registers, raster and window counters, and the running row maximum.
`default_nettype none
module mp2_window_ctrl #(
  parameter int MAX_MAP_WIDTH = mp2_pkg::DEF_MAX_MAP_WIDTH,
  parameter int MAX_POOL      = mp2_pkg::DEF_MAX_POOL,
  parameter int SAMPLE_BITS   = mp2_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [mp2_pkg::CFG_INDEX_BITS-1:0]    cfg_index_i,
  input  wire logic [mp2_pkg::CFG_DATA_BITS-1:0]     cfg_wdata_i,
  input  wire logic                                  accept_i,
  input  wire logic signed [SAMPLE_BITS-1:0]         sample_i,
  output logic [$clog2(MAX_MAP_WIDTH)-1:0]           rd_addr_o,
  output logic signed [SAMPLE_BITS-1:0]              run_max_o,
  output mp2_pkg::win_flags_t                        flags_o
);

  localparam int CIW = $clog2(MAX_MAP_WIDTH);
  localparam int MWW = $clog2(MAX_MAP_WIDTH + 1);
  localparam int PCW = $clog2(MAX_POOL + 1);
  localparam int WCW = $clog2(MAX_POOL);
  localparam int CLW = MWW + 1;
  localparam int RLW = mp2_pkg::MH_BITS + 1;
  localparam int MW_RESET = (MAX_MAP_WIDTH < mp2_pkg::MAP_RESET) ?
                            MAX_MAP_WIDTH : mp2_pkg::MAP_RESET;
  localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    int unsigned r;
    r = v;
    if (v == 0) begin
      r = 1;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  // Sizes are kept clamped, so the datapath never sees an out-of-range value.
  logic [PCW-1:0]                  pw_q, pw_d, ph_q, ph_d;
  logic [MWW-1:0]                  mw_q, mw_d;
  logic [mp2_pkg::MH_BITS-1:0]     mh_q, mh_d;

  logic [CIW-1:0]                  ci_q, ci_d, oc_q, oc_d;
  logic [mp2_pkg::ROW_BITS-1:0]    ri_q, ri_d;
  logic [WCW-1:0]                  wc_q, wc_d, wr_q, wr_d;
  logic signed [SAMPLE_BITS-1:0]   rm_q, rm_d;

  logic col_end, row_end, col_wrap, row_wrap, last;

  always_comb begin
    pw_d = pw_q;
    ph_d = ph_q;
    mw_d = mw_q;
    mh_d = mh_q;
    case (cfg_index_i)
      mp2_pkg::REG_POOL_WIDTH: begin
        pw_d = PCW'(clamp_size(32'(cfg_wdata_i[mp2_pkg::POOL_REG_BITS-1:0]), MAX_POOL));
      end
      mp2_pkg::REG_POOL_HEIGHT: begin
        ph_d = PCW'(clamp_size(32'(cfg_wdata_i[mp2_pkg::POOL_REG_BITS-1:0]), MAX_POOL));
      end
      mp2_pkg::REG_MAP_WIDTH: begin
        mw_d = MWW'(clamp_size(32'(cfg_wdata_i), MAX_MAP_WIDTH));
      end
      mp2_pkg::REG_MAP_HEIGHT: begin
        mh_d = mp2_pkg::MH_BITS'(clamp_size(32'(cfg_wdata_i), mp2_pkg::HEIGHT_LIMIT));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q <= PCW'(mp2_pkg::POOL_RESET);
      ph_q <= PCW'(mp2_pkg::POOL_RESET);
      mw_q <= MWW'(MW_RESET);
      mh_q <= mp2_pkg::MH_BITS'(mp2_pkg::HEIGHT_LIMIT);
    end else if (cfg_we_i) begin
      pw_q <= pw_d;
      ph_q <= ph_d;
      mw_q <= mw_d;
      mh_q <= mh_d;
    end
  end

  always_comb begin
    // Comparisons use >= so that counters left beyond a new limit wrap.
    col_end  = (PCW'(wc_q) + PCW'(1)) >= pw_q;
    row_end  = (PCW'(wr_q) + PCW'(1)) >= ph_q;
    col_wrap = (CLW'(ci_q) + CLW'(1)) >= CLW'(mw_q);
    row_wrap = (RLW'(ri_q) + RLW'(1)) >= RLW'(mh_q);
    last     = ((CLW'(ci_q) + CLW'(1) + CLW'(pw_q)) > CLW'(mw_q)) &&
               ((RLW'(ri_q) + RLW'(1) + RLW'(ph_q)) > RLW'(mh_q));

    rm_d = ((wc_q == '0) || (sample_i > rm_q)) ? sample_i : rm_q;

    ci_d = ci_q;
    oc_d = oc_q;
    wc_d = wc_q;
    ri_d = ri_q;
    wr_d = wr_q;
    if (col_wrap) begin
      ci_d = '0;
      oc_d = '0;
      wc_d = '0;
      if (row_wrap) begin
        ri_d = '0;
        wr_d = '0;
      end else begin
        ri_d = ri_q + 1'b1;
        wr_d = row_end ? '0 : wr_q + 1'b1;
      end
    end else begin
      ci_d = ci_q + 1'b1;
      if (col_end) begin
        wc_d = '0;
        oc_d = oc_q + 1'b1;
      end else begin
        wc_d = wc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ci_q <= '0;
      oc_q <= '0;
      wc_q <= '0;
      ri_q <= '0;
      wr_q <= '0;
      rm_q <= MOST_NEG;
    end else if (accept_i) begin
      ci_q <= ci_d;
      oc_q <= oc_d;
      wc_q <= wc_d;
      ri_q <= ri_d;
      wr_q <= wr_d;
      rm_q <= rm_d;
    end
  end

  assign rd_addr_o = oc_q;
  assign run_max_o = rm_d;
  assign flags_o   = '{use_line: (wr_q != '0), col_end: col_end,
                       row_end: row_end, last: last};

endmodule
`default_nettype wire

// ----- rtl/core/max_pool_2d_stream_core.sv -----
// Top level of the streaming non-overlapping 2-D max pooling core.
//
//   channel | dir | payload                        | handshake
//   --------+-----+--------------------------------+------------------------------
//   input   | in  | sample_i                       | in_valid_i, in_stall_o
//   output  | out | pooled_value_o, last_of_map_o  | out_valid_o, out_stall_i
//   config  | in  | cfg_index_i, cfg_wdata_i       | cfg_we_i, no stall
//
// The core takes one item per clock cycle while in_stall_o is low, limited by
// the single read-modify-write of the line store per item. A result moves from
// stage 1 into the output register after the item closing its window is accepted.
// After reset the line store holds no defined data; it needs no clearing pass,
// since the first row of every band of windows never uses the entry it reads.
// in_stall_o rises only when stage 1 holds a finished result, the output register
// is full and the downstream side stalls it.
`default_nettype none
`include "max_pool_2d_stream_core_defines.svh"
module max_pool_2d_stream_core #(
  parameter int MAX_MAP_WIDTH = mp2_pkg::DEF_MAX_MAP_WIDTH,
  parameter int MAX_POOL      = mp2_pkg::DEF_MAX_POOL,
  parameter int SAMPLE_BITS   = mp2_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [mp2_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire logic [mp2_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0]      sample_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]           pooled_value_o,
  output logic                                    last_of_map_o
);

  localparam int AW = $clog2(MAX_MAP_WIDTH);

  logic                          in_accept;
  logic [AW-1:0]                 rd_addr;
  logic signed [SAMPLE_BITS-1:0] run_max;
  mp2_pkg::win_flags_t           flags;

  // Stage 1: the item whose line entry is being read.
  logic                          s1_valid_q, s1_valid_d;
  mp2_pkg::win_flags_t           s1_flags_q;
  logic signed [SAMPLE_BITS-1:0] s1_max_q;
  logic [AW-1:0]                 s1_addr_q;
  logic                          byp_q, byp_d;
  logic signed [SAMPLE_BITS-1:0] byp_data_q;

  logic signed [SAMPLE_BITS-1:0] line_rdata, line_val, s1_comb;
  logic                          s1_produce, s1_go, mem_we;

  logic                          out_valid_q, out_valid_d, out_load;
  logic signed [SAMPLE_BITS-1:0] out_value_q;
  logic                          out_last_q;

  mp2_window_ctrl #(
    .MAX_MAP_WIDTH(MAX_MAP_WIDTH),
    .MAX_POOL     (MAX_POOL),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (in_accept),
    .sample_i   (sample_i),
    .rd_addr_o  (rd_addr),
    .run_max_o  (run_max),
    .flags_o    (flags)
  );

  mp2_line_mem #(
    .DEPTH(MAX_MAP_WIDTH),
    .WIDTH(SAMPLE_BITS),
    .AW   (AW)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(s1_addr_q),
    .wdata_i(s1_comb),
    .re_i   (in_accept),
    .raddr_i(rd_addr),
    .rdata_o(line_rdata)
  );

  // Stage 1 only blocks when it carries a result and the output register cannot
  // take it; items that just update the line store always move on.
  always_comb begin
    s1_produce = s1_valid_q && s1_flags_q.col_end && s1_flags_q.row_end;
    s1_go      = !(s1_produce && out_valid_q && out_stall_i);
    in_stall_o = !s1_go;
    in_accept  = in_valid_i && !in_stall_o;

    // An entry written in the very cycle it was read comes from the bypass.
    line_val = byp_q ? byp_data_q : line_rdata;
    s1_comb  = (s1_flags_q.use_line && (line_val > s1_max_q)) ? line_val : s1_max_q;

    mem_we   = s1_valid_q && s1_go && s1_flags_q.col_end && !s1_flags_q.row_end;
    byp_d    = mem_we && (s1_addr_q == rd_addr);

    s1_valid_d = in_accept || (s1_valid_q && !s1_go);

    out_load    = s1_produce && s1_go;
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        byp_q <= byp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_flags_q <= flags;
      s1_max_q   <= run_max;
      s1_addr_q  <= rd_addr;
      byp_data_q <= s1_comb;
    end
    if (out_load) begin
      out_value_q <= s1_comb;
      out_last_q  <= s1_flags_q.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pooled_value_o = out_value_q;
  assign last_of_map_o  = out_last_q;

  // A stall toward the source comes only from a blocked result behind a full output.
  `ASSERT_IMPLY(a_stall_cause, in_stall_o, s1_valid_q && out_valid_q && out_stall_i, "stray stall")
  // Line store updates never hold stage 1.
  `ASSERT_IMPLY(a_write_moves, s1_valid_q && !s1_produce, s1_go, "write item held in stage 1")
  // Every accepted item occupies stage 1 in the next cycle.
  `ASSERT_NEXT(a_accept_fills, in_accept, s1_valid_q, "accepted item lost before stage 1")

endmodule
`default_nettype wire

// ----- tb/sv/max_pool_2d_stream_core_tb.sv -----
// Self-checking testbench of the streaming 2-D max pooling core, with a window-maximum predictor.
module max_pool_2d_stream_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB          = mp2_pkg::DEF_SAMPLE_BITS;
  localparam int CIB         = mp2_pkg::CFG_INDEX_BITS;
  localparam int CDB         = mp2_pkg::CFG_DATA_BITS;
  localparam int LINE_AW     = $clog2(mp2_pkg::DEF_MAX_MAP_WIDTH);
  localparam int CLK_PERIOD  = 8;
  localparam int RESET_CYCLES = 6;
  // Results leave through stage 1 and the output register; leave some slack
  // before a register write and before the final verdict.
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 8;
  localparam int ITEM_TARGET   = 1550;
  localparam int RUN_LIMIT     = 200000;

  // How the testbench treats one row of stimulus: a register write, an item whose
  // result comes from the predictor, or an item whose outcome is typed in the row.
  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_ITEM,
    ROW_ITEM_RESULT,
    ROW_ITEM_QUIET
  } row_kind_e;

  typedef struct packed {
    row_kind_e      kind;
    logic [CIB-1:0] reg_index;
    logic [CDB-1:0] reg_value;
    logic [SB-1:0]  sample;
    logic [SB-1:0]  pooled;
    logic           last;
  } stim_row_t;

  typedef struct packed {
    logic [SB-1:0] value;
    logic          last;
  } pooled_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           cfg_we_i = 1'b0;
  logic [CIB-1:0] cfg_index_i = mp2_pkg::REG_POOL_WIDTH;
  logic [CDB-1:0] cfg_wdata_i = '0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  logic [SB-1:0]  sample_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  logic [SB-1:0]  pooled_value_o;
  logic           last_of_map_o;

  max_pool_2d_stream_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pooled_value_o(pooled_value_o),
    .last_of_map_o (last_of_map_o)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // Directed part. The first block runs a 1x1 map with zero-sized pool and map
  // registers, so every item is its own result and is flagged last. The second
  // block pools a 4x2 map with 2x2 windows, including a window made only of the
  // most negative value. The third block uses oversized pools on a 2x1 map that is
  // smaller than the window, so nothing comes out. The fourth block stops partway
  // through a row with an oversized map height and shrinks the map to 1x1, so the
  // counters wrap and the running maximum of the broken window carries over once.
  stim_row_t directed_rows [38] = '{
    '{ROW_CFG,         mp2_pkg::REG_POOL_WIDTH,  11'd0,    16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,         mp2_pkg::REG_POOL_HEIGHT, 11'd0,    16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,         mp2_pkg::REG_MAP_WIDTH,   11'd0,    16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,         mp2_pkg::REG_MAP_HEIGHT,  11'd0,    16'h0000, 16'h0000, 1'b0},
    '{ROW_ITEM_RESULT, mp2_pkg::REG_POOL_WIDTH,  11'd0,    16'h7fff, 16'h7fff, 1'b1},
    '{ROW_ITEM_RESULT, mp2_pkg::REG_POOL_WIDTH,  11'd0,    16'h8000, 16'h8000, 1'b1},
    '{ROW_ITEM_RESULT, mp2_pkg::REG_POOL_WIDTH,  11'd0,    16'hffff, 16'hffff, 1'b1},
    '{ROW_CFG,         mp2_pkg::REG_POOL_WIDTH,  11'd2,    16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,         mp2_pkg::REG_POOL_HEIGHT, 11'd2,    16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,         mp2_pkg::REG_MAP_WIDTH,   11'd4,    16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,         mp2_pkg::REG_MAP_HEIGHT,  11'd2,    16'h0000, 16'h0000, 1'b0},
    '{ROW_ITEM_QUIET,  mp2_pkg::REG_POOL_WIDTH,  11'd0,    16'h8000, 16'h0000, 1'b0},
    '{ROW_ITEM_QUIET,  mp2_pkg::REG_POOL_WIDTH,  11'd0,    16'h8000, 16'h0000, 1'b0},
    '{ROW_ITEM_QUIET,  mp2_pkg::REG_POOL_WIDTH,  11'd0,    16'h0005, 16'h0000, 1'b0},
    '{ROW_ITEM_QUIET,  mp2_pkg::REG_POOL_WIDTH,  11'd0,    16'hfffd, 16'h0000, 1'b0},
    '{ROW_ITEM_QUIET,  mp2_pkg::REG_POOL_WIDTH,  11'd0,    16'h8000, 16'h0000, 1'b0},
    '{ROW_ITEM_RESULT, mp2_pkg::REG_POOL_WIDTH,  11'd0,    16'h8000, 16'h8000, 1'b0},
    '{ROW_ITEM_QUIET,  mp2_pkg::REG_POOL_WIDTH,  11'd0,    16'hfff9, 16'h0000, 1'b0},
    '{ROW_ITEM_RESULT, mp2_pkg::REG_POOL_WIDTH,  11'd0,    16'h7fff, 16'h7fff, 1'b1},
    '{ROW_CFG,         mp2_pkg::REG_POOL_WIDTH,  11'd15,   16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,         mp2_pkg::REG_POOL_HEIGHT, 11'd9,    16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,         mp2_pkg::REG_MAP_WIDTH,   11'd2,    16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,         mp2_pkg::REG_MAP_HEIGHT,  11'd1,    16'h0000, 16'h0000, 1'b0},
    '{ROW_ITEM_QUIET,  mp2_pkg::REG_POOL_WIDTH,  11'd0,    16'h1234, 16'h0000, 1'b0},
    '{ROW_ITEM_QUIET,  mp2_pkg::REG_POOL_WIDTH,  11'd0,    16'h8001, 16'h0000, 1'b0},
    '{ROW_CFG,         mp2_pkg::REG_POOL_WIDTH,  11'd3,    16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,         mp2_pkg::REG_POOL_HEIGHT, 11'd0,    16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,         mp2_pkg::REG_MAP_WIDTH,   11'd5,    16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,         mp2_pkg::REG_MAP_HEIGHT,  11'd2047, 16'h0000, 16'h0000, 1'b0},
    '{ROW_ITEM,        mp2_pkg::REG_POOL_WIDTH,  11'd0,    16'h0100, 16'h0000, 1'b0},
    '{ROW_ITEM,        mp2_pkg::REG_POOL_WIDTH,  11'd0,    16'hff00, 16'h0000, 1'b0},
    '{ROW_ITEM,        mp2_pkg::REG_POOL_WIDTH,  11'd0,    16'h0200, 16'h0000, 1'b0},
    '{ROW_ITEM,        mp2_pkg::REG_POOL_WIDTH,  11'd0,    16'h7000, 16'h0000, 1'b0},
    '{ROW_CFG,         mp2_pkg::REG_POOL_WIDTH,  11'd1,    16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,         mp2_pkg::REG_MAP_WIDTH,   11'd1,    16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,         mp2_pkg::REG_MAP_HEIGHT,  11'd1,    16'h0000, 16'h0000, 1'b0},
    '{ROW_ITEM,        mp2_pkg::REG_POOL_WIDTH,  11'd0,    16'h0050, 16'h0000, 1'b0},
    '{ROW_ITEM_RESULT, mp2_pkg::REG_POOL_WIDTH,  11'd0,    16'h8000, 16'h8000, 1'b1}
  };

  // Expected results in output order, and one row per item sent, in input order,
  // that tells the checker how to treat the item when the core accepts it.
  pooled_t   pooled_expect_q[$];
  stim_row_t item_note_q[$];

  int error_count = 0;
  int cycle_count = 0;
  int items_sent  = 0;
  int tx_idle_pct = 37;
  int rx_idle_pct = 53;

  // Predictor state: register copies, the line of partial maxima and the counters.
  logic [mp2_pkg::POOL_REG_BITS-1:0] pool_w_reg, pool_h_reg;
  logic [mp2_pkg::MAP_REG_BITS-1:0]  map_w_reg, map_h_reg;
  logic signed [SB-1:0]              line_max [mp2_pkg::DEF_MAX_MAP_WIDTH];
  logic signed [SB-1:0]              row_max;
  int unsigned                       col_idx, row_idx, win_col, win_row, out_col;

  // A size register of zero behaves as one, and a value above the hardware
  // bound behaves as the bound.
  function automatic int unsigned effective_size(int unsigned raw, int unsigned hi);
    if (raw == 0) return 1;
    return (raw > hi) ? hi : raw;
  endfunction

  // Advances the pooling state by one sample and returns the window maximum when
  // the sample closes a window.
  function automatic void window_max_step(input logic [SB-1:0] raw, output bit produced,
                                          output pooled_t res);
    int unsigned          pw, ph, mw, mh;
    logic signed [SB-1:0] s, combined;
    bit                   col_end, row_end, in_line;
    pw = effective_size(32'(pool_w_reg), mp2_pkg::DEF_MAX_POOL);
    ph = effective_size(32'(pool_h_reg), mp2_pkg::DEF_MAX_POOL);
    mw = effective_size(32'(map_w_reg), mp2_pkg::DEF_MAX_MAP_WIDTH);
    mh = effective_size(32'(map_h_reg), mp2_pkg::HEIGHT_LIMIT);
    s = raw;
    col_end = (win_col + 1 >= pw);
    row_end = (win_row + 1 >= ph);
    produced = 1'b0;
    res = '0;
    if (win_col == 0 || s > row_max) row_max = s;
    if (col_end) begin
      combined = row_max;
      in_line = (out_col < mp2_pkg::DEF_MAX_MAP_WIDTH);
      if (win_row != 0 && in_line && line_max[out_col[LINE_AW-1:0]] > combined) begin
        combined = line_max[out_col[LINE_AW-1:0]];
      end
      if (row_end) begin
        produced = 1'b1;
        res.value = combined;
        res.last = (col_idx + 1 + pw > mw) && (row_idx + 1 + ph > mh);
      end else if (in_line) begin
        line_max[out_col[LINE_AW-1:0]] = combined;
      end
    end
    if (col_idx + 1 >= mw) begin
      col_idx = 0;
      win_col = 0;
      out_col = 0;
      if (row_idx + 1 >= mh) begin
        row_idx = 0;
        win_row = 0;
      end else begin
        row_idx++;
        win_row = row_end ? 0 : win_row + 1;
      end
    end else begin
      col_idx++;
      if (col_end) begin
        win_col = 0;
        out_col++;
      end else begin
        win_col++;
      end
    end
  endfunction

  // Checker. Everything is sampled right after the rising edge, so the values
  // seen are the ones the core saw at that edge. Register writes and accepted
  // items feed the predictor; accepted results are compared with the oldest
  // expectation.
  always @(posedge clk_i) begin
    bit        produced;
    pooled_t   res;
    pooled_t   want;
    stim_row_t note;
    if (!rst_ni) begin
      pool_w_reg = mp2_pkg::POOL_REG_BITS'(mp2_pkg::POOL_RESET);
      pool_h_reg = mp2_pkg::POOL_REG_BITS'(mp2_pkg::POOL_RESET);
      map_w_reg = mp2_pkg::MAP_REG_BITS'(mp2_pkg::MAP_RESET);
      map_h_reg = mp2_pkg::MAP_REG_BITS'(mp2_pkg::MAP_RESET);
      foreach (line_max[i]) line_max[i] = '0;
      row_max = {1'b1, {(SB-1){1'b0}}};
      col_idx = 0;
      row_idx = 0;
      win_col = 0;
      win_row = 0;
      out_col = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          mp2_pkg::REG_POOL_WIDTH:  pool_w_reg = cfg_wdata_i[mp2_pkg::POOL_REG_BITS-1:0];
          mp2_pkg::REG_POOL_HEIGHT: pool_h_reg = cfg_wdata_i[mp2_pkg::POOL_REG_BITS-1:0];
          mp2_pkg::REG_MAP_WIDTH:   map_w_reg = cfg_wdata_i[mp2_pkg::MAP_REG_BITS-1:0];
          mp2_pkg::REG_MAP_HEIGHT:  map_h_reg = cfg_wdata_i[mp2_pkg::MAP_REG_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        window_max_step(sample_i, produced, res);
        if (item_note_q.size() != 0) begin
          note = item_note_q.pop_front();
          // Rows with a typed outcome override the predictor for this item.
          if (note.kind == ROW_ITEM_RESULT) begin
            produced = 1'b1;
            res.value = note.pooled;
            res.last = note.last;
          end else if (note.kind == ROW_ITEM_QUIET) begin
            produced = 1'b0;
          end
        end
        if (produced) pooled_expect_q.push_back(res);
      end
      if (out_valid_o && !out_stall_i) begin
        if (pooled_expect_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got pooled_value %h last_of_map %b",
                   $time, pooled_value_o, last_of_map_o);
          error_count++;
        end else begin
          want = pooled_expect_q.pop_front();
          if (pooled_value_o !== want.value) begin
            $display("%0t ns: pooled_value expected %h, got %h", $time, want.value,
                     pooled_value_o);
            error_count++;
          end
          if (last_of_map_o !== want.last) begin
            $display("%0t ns: last_of_map expected %b, got %b", $time, want.last,
                     last_of_map_o);
            error_count++;
          end
        end
      end
    end
  end

  // The receiver stalls at random with the rate of the current idling mode.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Biased toward the two extremes and a cluster around zero so that windows
  // often hold ties.
  function automatic logic [SB-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(SB-1){1'b1}}};
      1:       return {1'b1, {(SB-1){1'b0}}};
      2:       return SB'($urandom_range(0, 6)) - SB'(3);
      default: return SB'($urandom);
    endcase
  endfunction

  // Holds the input side quiet until every expected result has been taken. The
  // first edge lets the checker record the result of an item accepted just now.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pooled_expect_q.size() != 0) @(posedge clk_i);
  endtask

  // Registers change only while the core is idle. Items that close no window
  // may still be in flight after the last result, hence the extra cycles.
  task automatic write_register(input logic [CIB-1:0] index,
                                input logic [CDB-1:0] value);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Sends one item and returns at the edge where the core accepts it. The
  // idling mode follows the count of items sent: the receiver stalls more first,
  // then the sender idles more, then neither holds back.
  task automatic send_sample(input stim_row_t row);
    if (items_sent < ITEM_TARGET / 3) begin
      tx_idle_pct = 37;
      rx_idle_pct = 53;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      tx_idle_pct = 53;
      rx_idle_pct = 37;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    item_note_q.push_back(row);
    in_valid_i <= 1'b1;
    sample_i <= row.sample;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // One random phase: a fresh setting of all four registers and whole maps of
  // random samples, so the counters are back at the map origin when it ends and
  // no line entry is ever read before it has been written. The wide phase runs
  // one full-width row with the widest pool, where the width clamp decides the
  // last flag.
  task automatic run_pool_phase(input bit wide, input bit must_pause);
    int unsigned pw_raw, ph_raw, mw_raw, mh_raw;
    int unsigned pw_eff, ph_eff, mw_eff, mh_eff;
    int unsigned cap, n_maps, n_items;
    int          pause_at;
    stim_row_t   row;
    if (wide) begin
      pw_raw = 15;
      ph_raw = 0;
      mw_raw = $urandom_range(0, 1) ? mp2_pkg::DEF_MAX_MAP_WIDTH : 2047;
      mh_raw = 0;
    end else begin
      pw_raw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
      ph_raw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
    end
    pw_eff = effective_size(pw_raw, mp2_pkg::DEF_MAX_POOL);
    ph_eff = effective_size(ph_raw, mp2_pkg::DEF_MAX_POOL);
    if (!wide) begin
      // Mostly whole windows, sometimes trailing columns or rows, now and then
      // a map narrower or shorter than the window.
      if ($urandom_range(0, 7) == 0) mw_raw = $urandom_range(0, pw_eff);
      else mw_raw = pw_eff * $urandom_range(1, 4) +
                    (($urandom_range(0, 2) == 0) ? $urandom_range(0, pw_eff - 1) : 0);
      cap = 300 / (effective_size(mw_raw, mp2_pkg::DEF_MAX_MAP_WIDTH) * ph_eff);
      if (cap < 1) cap = 1;
      if (cap > 4) cap = 4;
      if ($urandom_range(0, 7) == 0) mh_raw = $urandom_range(0, ph_eff);
      else mh_raw = ph_eff * $urandom_range(1, cap) +
                    (($urandom_range(0, 2) == 0) ? $urandom_range(0, ph_eff - 1) : 0);
    end
    mw_eff = effective_size(mw_raw, mp2_pkg::DEF_MAX_MAP_WIDTH);
    mh_eff = effective_size(mh_raw, mp2_pkg::HEIGHT_LIMIT);
    n_maps = (!wide && mw_eff * mh_eff < 64) ? $urandom_range(1, 4) : 1;
    n_items = n_maps * mw_eff * mh_eff;
    write_register(mp2_pkg::REG_POOL_WIDTH, CDB'(pw_raw));
    write_register(mp2_pkg::REG_POOL_HEIGHT, CDB'(ph_raw));
    write_register(mp2_pkg::REG_MAP_WIDTH, CDB'(mw_raw));
    write_register(mp2_pkg::REG_MAP_HEIGHT, CDB'(mh_raw));
    pause_at = -1;
    if (must_pause || $urandom_range(0, 3) == 0) begin
      pause_at = int'($urandom_range(0, n_items - 1));
    end
    for (int i = 0; i < n_items; i++) begin
      row = '0;
      row.kind = ROW_ITEM;
      row.sample = random_sample();
      send_sample(row);
      // Hold the stream after a random item of the phase until the core has drained.
      if (i == pause_at) wait_for_results();
    end
  endtask

  initial begin
    bit wide_done;
    int phase_no;
    wide_done = 1'b0;
    phase_no = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
      end else begin
        send_sample(directed_rows[i]);
      end
    end
    while (items_sent < ITEM_TARGET) begin
      if (!wide_done && items_sent >= 400) begin
        run_pool_phase(1'b1, 1'b0);
        wide_done = 1'b1;
      end else begin
        run_pool_phase(1'b0, phase_no == 0);
      end
      phase_no++;
    end
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pooled_expect_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/mp2_pkg.sv
rtl/core/mp2_line_mem.sv
rtl/core/mp2_window_ctrl.sv
rtl/core/max_pool_2d_stream_core.sv
tb/sv/max_pool_2d_stream_core_tb.sv
